[rtl/core/brl_pkg.sv]
// Shared types and constants of the Bresenham line rasterizer.
// No dependencies; every other file of the core uses it.
package brl_pkg;

    // Fixed field widths at the block boundary
    localparam int unsigned InCoordW = 9;
    localparam int unsigned ColourW  = 16;
    localparam int unsigned PixelW   = 18;
    localparam int unsigned CountW   = 4;
    localparam int unsigned SlotMax  = 8;
    localparam int unsigned SlotIdxW = $clog2(SlotMax);

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch endpoints and colour of an accepted line
        logic setup;     // pick the major axis, swap coordinates when steep
        logic order;     // order endpoints, load deltas and error term
        logic walk;      // one Bresenham step into the group being built
        logic step;      // move the built group into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;      // the group being built is complete
        logic last;      // no pixels remain: the built group is the final one
    } t_dp_stat;

    typedef logic [PixelW-1:0] t_pixel;

endpackage

[rtl/core/brl_if.sv]
// Handshake channels of the Bresenham line rasterizer: line in, pixel group out.
// Depends on brl_pkg for the field widths.
interface brl_line_if;
    logic                              valid;
    logic                              ready;
    logic [brl_pkg::InCoordW-1:0]      start_x;
    logic [brl_pkg::InCoordW-1:0]      start_y;
    logic [brl_pkg::InCoordW-1:0]      end_x;
    logic [brl_pkg::InCoordW-1:0]      end_y;
    logic [brl_pkg::ColourW-1:0]       colour;

    modport source (output valid, start_x, start_y, end_x, end_y, colour, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

interface brl_group_if;
    logic                              valid;
    logic                              ready;
    logic [brl_pkg::CountW-1:0]        pixel_count;
    logic [brl_pkg::PixelW-1:0]        pixel_a;
    logic [brl_pkg::PixelW-1:0]        pixel_b;
    logic [brl_pkg::PixelW-1:0]        pixel_c;
    logic [brl_pkg::PixelW-1:0]        pixel_d;
    logic [brl_pkg::PixelW-1:0]        pixel_e;
    logic [brl_pkg::PixelW-1:0]        pixel_f;
    logic [brl_pkg::PixelW-1:0]        pixel_g;
    logic [brl_pkg::PixelW-1:0]        pixel_h;
    logic [brl_pkg::ColourW-1:0]       pixel_colour;
    logic                              last_group;

    modport source (output valid, pixel_count, pixel_a, pixel_b, pixel_c, pixel_d,
                    pixel_e, pixel_f, pixel_g, pixel_h, pixel_colour, last_group,
                    input ready);
    modport sink   (input valid, pixel_count, pixel_a, pixel_b, pixel_c, pixel_d,
                    pixel_e, pixel_f, pixel_g, pixel_h, pixel_colour, last_group,
                    output ready);
endinterface

[rtl/core/brl_ctrl.sv]
// Controller of the Bresenham line rasterizer: sequences setup, the pixel walk and
// the group hand-off, owns both handshakes and the output valid flag. Depends on brl_pkg.
module brl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output brl_pkg::t_dp_cmd  o_cmd,
    input  brl_pkg::t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_ORDER = 2'd2;
    localparam logic [1:0] S_RUN   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // built group complete and output register free or being emptied this cycle
    assign load = (r_state == S_RUN) && i_stat.full && (!r_out_valid || i_out_ready);

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.step    = load;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_ORDER;
            end
            S_ORDER: begin
                o_cmd.order = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (!i_stat.full) begin
                    o_cmd.walk = 1'b1;
                end else if (load && i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output valid: set on a load, cleared when the beat is taken
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/core/brl_dpath.sv]
// Datapath of the Bresenham line rasterizer: endpoint setup, walk state, a one-step walk unit
// building groups of up to PIXELS_PER_GROUP pixels and the output register. Depends on brl_pkg.
module brl_dpath #(
    parameter int unsigned COORD_BITS       = 9,
    parameter int unsigned PIXELS_PER_GROUP = 8
) (
    input  logic                            i_clk,
    input  brl_pkg::t_dp_cmd                i_cmd,
    output brl_pkg::t_dp_stat               o_stat,
    input  logic [brl_pkg::InCoordW-1:0]    i_start_x,
    input  logic [brl_pkg::InCoordW-1:0]    i_start_y,
    input  logic [brl_pkg::InCoordW-1:0]    i_end_x,
    input  logic [brl_pkg::InCoordW-1:0]    i_end_y,
    input  logic [brl_pkg::ColourW-1:0]     i_colour,
    output logic [brl_pkg::CountW-1:0]      o_pixel_count,
    output brl_pkg::t_pixel                 o_pixel [brl_pkg::SlotMax],
    output logic [brl_pkg::ColourW-1:0]     o_pixel_colour,
    output logic                            o_last_group
);

    localparam int unsigned ErrW  = COORD_BITS + 2;
    localparam int unsigned PackW = (2 * COORD_BITS > brl_pkg::PixelW) ?
                                    2 * COORD_BITS : brl_pkg::PixelW;
    localparam logic [brl_pkg::CountW-1:0] GroupMax = brl_pkg::CountW'(PIXELS_PER_GROUP);

    // captured endpoints
    logic [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [brl_pkg::ColourW-1:0] r_line_colour;
    // endpoints in major/minor terms
    logic [COORD_BITS-1:0] r_maj0, r_min0, r_maj1, r_min1;
    logic                  r_axes_swapped;
    // walk state
    logic [COORD_BITS-1:0]  r_major_pos, r_minor_pos, r_delta_major, r_delta_minor, r_remain;
    logic signed [ErrW-1:0] r_error_term;
    logic                   r_minor_down;
    // group being built
    logic [brl_pkg::CountW-1:0]  r_acc_n;
    brl_pkg::t_pixel             r_acc_pix [brl_pkg::SlotMax];
    // output register
    logic [brl_pkg::CountW-1:0]  r_cnt;
    brl_pkg::t_pixel             r_pix [brl_pkg::SlotMax];
    logic [brl_pkg::ColourW-1:0] r_out_colour;
    logic                        r_last;

    // setup: absolute deltas and steepness
    logic [COORD_BITS-1:0] s_adx, s_ady;
    logic                  s_steep;
    always_comb begin
        s_adx   = (r_x1 >= r_x0) ? (r_x1 - r_x0) : (r_x0 - r_x1);
        s_ady   = (r_y1 >= r_y0) ? (r_y1 - r_y0) : (r_y0 - r_y1);
        s_steep = (s_ady > s_adx);
    end

    // order: increasing major axis, deltas and initial error
    logic [COORD_BITS-1:0]  o_lo_maj, o_hi_maj, o_lo_min, o_hi_min, o_dmaj, o_dmin;
    logic signed [ErrW-1:0] o_err0;
    always_comb begin
        if (r_maj0 > r_maj1) begin
            o_lo_maj = r_maj1;
            o_lo_min = r_min1;
            o_hi_maj = r_maj0;
            o_hi_min = r_min0;
        end else begin
            o_lo_maj = r_maj0;
            o_lo_min = r_min0;
            o_hi_maj = r_maj1;
            o_hi_min = r_min1;
        end
        o_dmaj = o_hi_maj - o_lo_maj;
        o_dmin = (o_hi_min >= o_lo_min) ? (o_hi_min - o_lo_min) : (o_lo_min - o_hi_min);
        o_err0 = -$signed({2'b00, (o_dmaj >> 1)});
    end

    // walk unit: one Bresenham step per cycle while the group being built is not complete
    logic [COORD_BITS-1:0]  w_px, w_py, w_min;
    logic signed [ErrW-1:0] w_err_add, w_err;
    logic [PackW-1:0]       w_pack;
    always_comb begin
        w_px      = r_axes_swapped ? r_minor_pos : r_major_pos;
        w_py      = r_axes_swapped ? r_major_pos : r_minor_pos;
        w_pack    = PackW'({w_py, w_px});
        w_err_add = r_error_term + $signed({2'b00, r_delta_minor});
        w_min     = r_minor_pos;
        w_err     = w_err_add;
        if (w_err_add > 0) begin
            w_min = r_minor_down ? (r_minor_pos - 1'b1) : (r_minor_pos + 1'b1);
            w_err = w_err_add - $signed({2'b00, r_delta_major});
        end
    end

    // group complete when all slots are used or the line is exhausted
    always_comb begin
        o_stat.full = (r_acc_n == GroupMax) || (r_remain == '0);
        o_stat.last = (r_remain == '0);
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x0          <= COORD_BITS'(i_start_x);
            r_y0          <= COORD_BITS'(i_start_y);
            r_x1          <= COORD_BITS'(i_end_x);
            r_y1          <= COORD_BITS'(i_end_y);
            r_line_colour <= i_colour;
        end
        if (i_cmd.setup) begin
            r_axes_swapped <= s_steep;
            r_maj0         <= s_steep ? r_y0 : r_x0;
            r_min0         <= s_steep ? r_x0 : r_y0;
            r_maj1         <= s_steep ? r_y1 : r_x1;
            r_min1         <= s_steep ? r_x1 : r_y1;
        end
        if (i_cmd.order) begin
            r_major_pos   <= o_lo_maj;
            r_minor_pos   <= o_lo_min;
            r_delta_major <= o_dmaj;
            r_delta_minor <= o_dmin;
            r_remain      <= o_dmaj;
            r_error_term  <= o_err0;
            r_minor_down  <= !(o_lo_min < o_hi_min);
            r_acc_n       <= '0;
            r_acc_pix     <= '{default: '0};
        end
        if (i_cmd.walk) begin
            r_major_pos  <= r_major_pos + 1'b1;
            r_minor_pos  <= w_min;
            r_error_term <= w_err;
            r_remain     <= r_remain - 1'b1;
            r_acc_n      <= r_acc_n + 1'b1;
            r_acc_pix[r_acc_n[brl_pkg::SlotIdxW-1:0]] <= w_pack[brl_pkg::PixelW-1:0];
        end
        if (i_cmd.step) begin
            r_cnt        <= r_acc_n;
            r_pix        <= r_acc_pix;
            r_out_colour <= r_line_colour;
            r_last       <= (r_remain == '0);
            r_acc_n      <= '0;
            r_acc_pix    <= '{default: '0};
        end
    end

    assign o_pixel_count  = r_cnt;
    assign o_pixel        = r_pix;
    assign o_pixel_colour = r_out_colour;
    assign o_last_group   = r_last;

endmodule

[rtl/core/bresenham_line_rasterizer_core.sv]
// Top level of the Bresenham line rasterizer: controller plus datapath.
// Depends on brl_pkg, brl_if (brl_line_if, brl_group_if), brl_ctrl and brl_dpath.
//
// One line beat in gives its pixels as groups of up to PIXELS_PER_GROUP packed
// positions (y << COORD_BITS | x, low 18 bits), drawing order, far endpoint not
// drawn; the final group carries last_group, and a zero-length line gives a single
// empty group. A line is taken only while the block is idle: it is accepted in the idle
// state, goes through the setup steps (axis select, endpoint ordering), then walks its
// pixels one Bresenham step at a time and moves each complete group into the output
// register. The rate is set by the walk unit, which takes one error-term step per cycle
// while the group being built is not yet complete. Groups stall in the output register
// while the sink holds off; the walk keeps filling the next group meanwhile until it is
// complete, and the next line may be accepted and set up while the last group of the
// previous line still waits.
module bresenham_line_rasterizer_core #(
    parameter int unsigned COORD_BITS       = 9,
    parameter int unsigned PIXELS_PER_GROUP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brl_line_if.sink    i_line,
    brl_group_if.source o_group
);

    brl_pkg::t_dp_cmd  cmd;
    brl_pkg::t_dp_stat stat;
    brl_pkg::t_pixel   pix [brl_pkg::SlotMax];

    brl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_group.valid),
        .i_out_ready (o_group.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    brl_dpath #(
        .COORD_BITS       (COORD_BITS),
        .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_start_x      (i_line.start_x),
        .i_start_y      (i_line.start_y),
        .i_end_x        (i_line.end_x),
        .i_end_y        (i_line.end_y),
        .i_colour       (i_line.colour),
        .o_pixel_count  (o_group.pixel_count),
        .o_pixel        (pix),
        .o_pixel_colour (o_group.pixel_colour),
        .o_last_group   (o_group.last_group)
    );

    // group slots onto the output channel
    assign o_group.pixel_a = pix[0];
    assign o_group.pixel_b = pix[1];
    assign o_group.pixel_c = pix[2];
    assign o_group.pixel_d = pix[3];
    assign o_group.pixel_e = pix[4];
    assign o_group.pixel_f = pix[5];
    assign o_group.pixel_g = pix[6];
    assign o_group.pixel_h = pix[7];

endmodule

[sim/tb_bresenham_line_rasterizer_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench of bresenham_line_rasterizer_core: line beats in, pixel groups out.
// Needs brl_pkg, brl_if and the core RTL; reads nothing else.
module tb_bresenham_line_rasterizer_core;

    // Package constants and types used here
    localparam int unsigned InCoordW = brl_pkg::InCoordW;
    localparam int unsigned ColourW  = brl_pkg::ColourW;
    localparam int unsigned CountW   = brl_pkg::CountW;
    localparam int unsigned SlotMax  = brl_pkg::SlotMax;
    typedef brl_pkg::t_pixel t_pixel;

    localparam int unsigned PIX_PER_GROUP = 8;
    localparam int unsigned RAND_LINES    = 196;
    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned DRAIN_CYCLES  = 80;
    localparam int unsigned NUM_ROWS      = 24;

    // One pixel group as the sink sees it; pix[0] is slot a
    typedef struct packed {
        logic [CountW-1:0]      count;
        t_pixel [SlotMax-1:0]   pix;
        logic [ColourW-1:0]     colour;
        logic                   last;
    } t_group;

    // One stimulus line; typed rows carry their single expected group as a pixel run
    typedef struct packed {
        logic [InCoordW-1:0] sx;
        logic [InCoordW-1:0] sy;
        logic [InCoordW-1:0] ex;
        logic [InCoordW-1:0] ey;
        logic [ColourW-1:0]  colour;
        logic                typed;
        logic [CountW-1:0]   cnt;
        t_pixel              base;
        logic [9:0]          stride;
    } t_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_BLOCK
    } t_stall;

    logic i_clk;
    logic i_rst_n;

    brl_line_if  line_ch ();
    brl_group_if group_ch ();

    bresenham_line_rasterizer_core #(
        .COORD_BITS       (InCoordW),
        .PIXELS_PER_GROUP (PIX_PER_GROUP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_ch),
        .o_group (group_ch)
    );

    // Directed lines: corners, both directions of both axes, group boundaries, rounding
    t_row dir_table [NUM_ROWS] = '{
        // zero-length lines: one empty last group
        '{9'd0,   9'd0,   9'd0,   9'd0,   16'h0000, 1'b1, 4'd0, 18'd0,      10'd0},
        '{9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF, 1'b1, 4'd0, 18'd0,      10'd0},
        // exactly one full horizontal group
        '{9'd0,   9'd0,   9'd8,   9'd0,   16'hF800, 1'b1, 4'd8, 18'd0,      10'd1},
        // reversed endpoints on the bottom row
        '{9'd8,   9'd511, 9'd0,   9'd511, 16'h07E0, 1'b1, 4'd8, 18'd261632, 10'd1},
        // short vertical: axes swapped, steps of one row; then a one-pixel horizontal line
        '{9'd5,   9'd0,   9'd5,   9'd3,   16'h001F, 1'b1, 4'd3, 18'd5,      10'd512},
        '{9'd0,   9'd0,   9'd1,   9'd0,   16'hAAAA, 1'b1, 4'd1, 18'd0,      10'd0},
        // predicted rows
        '{9'd0,   9'd0,   9'd511, 9'd511, 16'h1234, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd511, 9'd511, 9'd0,   16'h4321, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd511, 9'd0,   9'd0,   9'd511, 16'hFFFF, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd5,   9'd511, 9'd5,   16'h0000, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd7,   9'd0,   9'd7,   9'd511, 16'h8000, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd0,   9'd9,   9'd0,   16'h0001, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd0,   9'd16,  9'd0,   16'h5555, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd0,   9'd3,   9'd1,   16'hAAAA, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd0,   9'd5,   9'd2,   16'h0F0F, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd10,  9'd10,  9'd20,  9'd11,  16'hF0F0, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd20,  9'd11,  9'd10,  9'd10,  16'h00FF, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd100, 9'd100, 9'd103, 9'd110, 16'hFF00, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd100, 9'd110, 9'd103, 9'd100, 16'h7FFF, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd50,  9'd50,  9'd60,  9'd60,  16'hFFFE, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd50,  9'd50,  9'd60,  9'd61,  16'h8001, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd300, 9'd200, 9'd300, 9'd100, 16'h5555, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd0,   9'd0,   9'd1,   9'd1,   16'hC3C3, 1'b0, 4'd0, 18'd0, 10'd0},
        '{9'd1,   9'd0,   9'd0,   9'd0,   16'h3C3C, 1'b0, 4'd0, 18'd0, 10'd0}
    };

    // Expected groups in arrival order, and lines driven but not yet accepted
    t_group pending_groups [$];
    t_row   sent_rows [$];

    // Walk state of the line predictor
    logic [InCoordW-1:0] walk_major;
    logic [InCoordW-1:0] walk_minor;
    logic [InCoordW-1:0] far_major;
    logic [InCoordW-1:0] span_major;
    logic [InCoordW-1:0] span_minor;
    logic signed [10:0]  walk_err;
    logic                minor_dec;
    logic                steep;
    logic [ColourW-1:0]  line_col;

    int unsigned mismatches;
    int unsigned lines_in;
    int unsigned groups_out;
    int unsigned pixels_out;
    int unsigned idle_cycles;

    // Predictor: walk one line and queue every group it must produce
    function automatic void walk_line(logic [InCoordW-1:0] sx, logic [InCoordW-1:0] sy,
                                      logic [InCoordW-1:0] ex, logic [InCoordW-1:0] ey,
                                      logic [ColourW-1:0] colour);
        int x0, y0, x1, y1, tmp, adx, ady;
        int done_px, n;
        t_group grp;
        x0 = int'(sx);
        y0 = int'(sy);
        x1 = int'(ex);
        y1 = int'(ey);
        line_col = colour;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = (ady > adx);
        if (steep) begin
            tmp = x0; x0 = y0; y0 = tmp;
            tmp = x1; x1 = y1; y1 = tmp;
        end
        // major coordinate must increase
        if (x0 > x1) begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
        end
        walk_major = InCoordW'(x0);
        walk_minor = InCoordW'(y0);
        far_major  = InCoordW'(x1);
        span_major = InCoordW'(x1 - x0);
        span_minor = InCoordW'((y1 > y0) ? y1 - y0 : y0 - y1);
        walk_err   = -$signed({3'b000, span_major[8:1]});
        minor_dec  = !(y0 < y1);
        done_px = 0;
        do begin
            grp = '0;
            n = 0;
            while (n < PIX_PER_GROUP && done_px < int'(span_major)) begin
                grp.pix[n] = steep ? {walk_major, walk_minor} : {walk_minor, walk_major};
                n++;
                done_px++;
                walk_err = walk_err + $signed({2'b00, span_minor});
                if (walk_err > 0) begin
                    walk_minor = minor_dec ? walk_minor - 1'b1 : walk_minor + 1'b1;
                    walk_err   = walk_err - $signed({2'b00, span_major});
                end
                walk_major = walk_major + 1'b1;
            end
            grp.count  = CountW'(n);
            grp.colour = line_col;
            grp.last   = (done_px >= int'(span_major));
            pending_groups.push_back(grp);
        end while (done_px < int'(span_major));
    endfunction

    function automatic logic [InCoordW-1:0] clamp_coord(int v);
        return (v < 0) ? '0 : (v > 511) ? 9'd511 : InCoordW'(v);
    endfunction

    // Clock and reset
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Group sink: ready follows the stall patterns in turn, selected by the cycle counter
    initial begin : group_sink
        int unsigned cyc;
        t_stall mode;
        group_ch.ready = 1'b0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            mode = t_stall'(cyc[9:8]);
            case (mode)
                STALL_NONE:   group_ch.ready <= 1'b1;
                STALL_RANDOM: group_ch.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: group_ch.ready <= (cyc[1:0] == 2'd0);
                STALL_BLOCK:  group_ch.ready <= (cyc[5:4] != 2'b11);
                default:      group_ch.ready <= 1'b1;
            endcase
        end
    end

    // Scoreboard: check accepted groups, predict accepted lines, watchdog
    always @(posedge i_clk) begin : scoreboard
        t_group got;
        t_group want;
        t_row   row;
        logic   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (group_ch.valid && group_ch.ready) begin
                moved = 1'b1;
                got.count  = group_ch.pixel_count;
                got.pix    = {group_ch.pixel_h, group_ch.pixel_g, group_ch.pixel_f,
                              group_ch.pixel_e, group_ch.pixel_d, group_ch.pixel_c,
                              group_ch.pixel_b, group_ch.pixel_a};
                got.colour = group_ch.pixel_colour;
                got.last   = group_ch.last_group;
                if (pending_groups.size() == 0) begin
                    mismatches++;
                    $error("pixel group beat with no group expected (count %0d)", got.count);
                end else begin
                    want = pending_groups.pop_front();
                    groups_out++;
                    pixels_out += got.count;
                    if (got.count !== want.count) begin
                        mismatches++;
                        $error("pixel_count expected %0d, got %0d", want.count, got.count);
                    end
                    for (int k = 0; k < SlotMax; k++) begin
                        if (got.pix[k] !== want.pix[k]) begin
                            mismatches++;
                            $error("pixel_%c expected %0d, got %0d", 8'(97 + k),
                                   want.pix[k], got.pix[k]);
                        end
                    end
                    if (got.colour !== want.colour) begin
                        mismatches++;
                        $error("pixel_colour expected %0h, got %0h", want.colour, got.colour);
                    end
                    if (got.last !== want.last) begin
                        mismatches++;
                        $error("last_group expected %0d, got %0d", want.last, got.last);
                    end
                end
            end
            if (line_ch.valid && line_ch.ready) begin
                moved = 1'b1;
                lines_in++;
                row = sent_rows.pop_front();
                if (row.typed) begin
                    want = '0;
                    want.count = row.cnt;
                    for (int k = 0; k < int'(row.cnt); k++)
                        want.pix[k] = t_pixel'(row.base + k * row.stride);
                    want.colour = row.colour;
                    want.last   = 1'b1;
                    pending_groups.push_back(want);
                end else begin
                    walk_line(line_ch.start_x, line_ch.start_y, line_ch.end_x, line_ch.end_y,
                              line_ch.colour);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Line source: directed rows, then random lines, sent in bursts with gaps
    initial begin : line_driver
        t_row row;
        int burst_left, gap, kind;
        line_ch.valid   = 1'b0;
        line_ch.start_x = '0;
        line_ch.start_y = '0;
        line_ch.end_x   = '0;
        line_ch.end_y   = '0;
        line_ch.colour  = '0;
        mismatches  = 0;
        lines_in    = 0;
        groups_out  = 0;
        pixels_out  = 0;
        idle_cycles = 0;
        do @(posedge i_clk); while (!i_rst_n);
        burst_left = 0;
        for (int i = 0; i < NUM_ROWS + RAND_LINES; i++) begin
            if (i < NUM_ROWS) begin
                row = dir_table[i];
            end else begin
                // mostly short lines, some full-screen, axis-aligned, degenerate and corners
                row = '0;
                kind = $urandom_range(0, 99);
                row.sx = InCoordW'($urandom_range(0, 511));
                row.sy = InCoordW'($urandom_range(0, 511));
                if (kind < 55) begin
                    row.ex = clamp_coord(int'(row.sx) + int'($urandom_range(0, 40)) - 20);
                    row.ey = clamp_coord(int'(row.sy) + int'($urandom_range(0, 40)) - 20);
                end else if (kind < 80) begin
                    row.ex = InCoordW'($urandom_range(0, 511));
                    row.ey = InCoordW'($urandom_range(0, 511));
                end else if (kind < 88) begin
                    if ($urandom_range(0, 1)) begin
                        row.ex = InCoordW'($urandom_range(0, 511));
                        row.ey = row.sy;
                    end else begin
                        row.ex = row.sx;
                        row.ey = InCoordW'($urandom_range(0, 511));
                    end
                end else if (kind < 94) begin
                    row.ex = clamp_coord(int'(row.sx) + int'($urandom_range(0, 2)) - 1);
                    row.ey = row.sy;
                end else begin
                    row.sx = {InCoordW{1'($urandom_range(0, 1))}};
                    row.sy = {InCoordW{1'($urandom_range(0, 1))}};
                    row.ex = {InCoordW{1'($urandom_range(0, 1))}};
                    row.ey = {InCoordW{1'($urandom_range(0, 1))}};
                end
                row.colour = ($urandom_range(0, 7) == 0) ? {ColourW{1'($urandom_range(0, 1))}}
                                                         : ColourW'($urandom);
            end
            // new burst: maybe drop valid for a while first
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    line_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            sent_rows.push_back(row);
            line_ch.valid   <= 1'b1;
            line_ch.start_x <= row.sx;
            line_ch.start_y <= row.sy;
            line_ch.end_x   <= row.ex;
            line_ch.end_y   <= row.ey;
            line_ch.colour  <= row.colour;
            do @(posedge i_clk); while (!line_ch.ready);
        end
        line_ch.valid <= 1'b0;

        // drain, then give the block time to show any stray group
        while (pending_groups.size() != 0 || sent_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Rasterized %0d lines (%0d directed, %0d random) into %0d groups, %0d pixels",
                 lines_in, NUM_ROWS, RAND_LINES, groups_out, pixels_out);
        $display("Field mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
